/* src/assert_macros.svh */
// assertion macros shared by the merge heap rtl
// depends on a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every rising clock edge out of reset
`define KWM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/kwm_pkg.sv */
// shared types and constants of the k-way merge heap unit
// no dependencies
package kwm_pkg;

    localparam int VALUE_W = 32;
    localparam int LID_W   = 6;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [LID_W-1:0]          t_lid;

    // one heap slot: list id and the cached head value of that list
    typedef struct packed {
        t_lid   id;
        t_value val;
    } t_entry;

    // request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // compare unit verdict
    typedef struct packed {
        logic go_left;
        logic go_right;
        logic up_swap;
    } t_cmp_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_HB_NEXT,
        ST_HB_LD,
        ST_SD_RD,
        ST_SD_CMP,
        ST_POP_RD,
        ST_POP_TAKE,
        ST_RF_RD,
        ST_RF_LD,
        ST_SU_RD,
        ST_SU_CMP,
        ST_DONE
    } t_state;

endpackage

/* src/kwm_cmp.sv */
// shared head comparator for sift-down and sift-up steps
// depends on kwm_pkg
module kwm_cmp (
    input  kwm_pkg::t_value   i_x,
    input  kwm_pkg::t_value   i_a,
    input  kwm_pkg::t_value   i_b,
    input  logic              i_b_ok,
    output kwm_pkg::t_cmp_res o_res
);

    logic           lt_l;
    logic           lt_r;
    kwm_pkg::t_value key_s;

    // sift-down: strict less-than, left child preferred on ties
    always_comb begin
        lt_l  = i_a < i_x;
        key_s = lt_l ? i_a : i_x;
        lt_r  = i_b_ok && (i_b < key_s);
        o_res.go_right = lt_r;
        o_res.go_left  = lt_l && !lt_r;
        // sift-up: parent moves down on strict greater-than
        o_res.up_swap  = i_a > i_x;
    end

endmodule

/* src/k_way_merge_min_heap_unit.sv */
// top level of the k-way merge heap unit: sequencer, list store, heap ram
// depends on kwm_pkg, kwm_cmp and assert_macros.svh
//
// A load request (kind 0) gives no result; busy stays low.
// A pop request (kind 1) raises busy and gives exactly one result strobe,
// which the receiver must take in that cycle. The first pop after loading
// first builds the heap: it writes the head of each non-empty list into a
// heap slot, then sifts down each slot that has children, from the bottom up.
// A pop itself reads the root and the last slot, sifts the last slot down
// from the root, fetches the list's next head when it is reinserted and sifts
// it up, and then gives the result strobe. The sequence is paced by the single
// write port of the heap ram and the one shared comparator, used once per
// heap level.
`include "assert_macros.svh"

module k_way_merge_min_heap_unit #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [2:0]  i_list_id,
    input  logic signed [31:0] i_value,
    output logic        o_res_strobe,
    output logic signed [31:0] o_value_res,
    output logic [2:0]  o_source_list,
    output logic        o_valid_res,
    output logic        o_last,
    output logic        o_overflow
);

    localparam int IDW   = $clog2(NUM_LISTS);
    localparam int CNTW  = $clog2(NUM_LISTS + 1);
    localparam int LENW  = $clog2(LIST_DEPTH + 1);
    localparam int OFFW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int ADDRW = $clog2(NUM_LISTS * LIST_DEPTH);

    // state and per-list bookkeeping
    kwm_pkg::t_state r_state, n_state;
    logic [LENW-1:0] r_len [NUM_LISTS];
    logic [LENW-1:0] r_cur [NUM_LISTS];
    logic [CNTW-1:0] r_n;
    logic [CNTW-1:0] r_p;
    logic [CNTW-1:0] r_i;
    logic [CNTW-1:0] r_fid;
    logic            r_merging;
    logic            r_ovf;
    logic            r_ctx_pop;
    kwm_pkg::t_entry r_x;
    kwm_pkg::t_lid   r_src;
    kwm_pkg::t_value r_out_val;
    kwm_pkg::t_lid   r_out_src;
    logic            r_out_vld;

    // memories
    kwm_pkg::t_value r_store [NUM_LISTS * LIST_DEPTH];
    kwm_pkg::t_value r_st_rd;
    kwm_pkg::t_entry r_heap [NUM_LISTS];
    kwm_pkg::t_entry r_rda;
    kwm_pkg::t_entry r_rdb;

    // control from the output decode
    logic            accept;
    logic            ld_id_ok;
    logic [IDW-1:0]  ld_idx;
    logic [LENW-1:0] ld_len;
    logic            st_we;
    logic [ADDRW-1:0] st_waddr;
    logic [ADDRW-1:0] st_raddr;
    logic            hp_we;
    logic [IDW-1:0]  hp_waddr;
    kwm_pkg::t_entry hp_wdata;
    logic [IDW-1:0]  hp_ra;
    logic [IDW-1:0]  hp_rb;

    // index arithmetic
    logic [CNTW:0]   l_pos;
    logic [CNTW:0]   r_pos;
    logic            l_in;
    logic            r_in;
    logic [CNTW-1:0] par_pos;
    logic [IDW-1:0]  fid_idx;
    logic [IDW-1:0]  src_idx;
    logic            refill;
    kwm_pkg::t_cmp_res cmp;

    function automatic logic [ADDRW-1:0] st_addr(input logic [IDW-1:0] id,
                                                  input logic [OFFW-1:0] off);
        st_addr = ADDRW'(id) * ADDRW'(LIST_DEPTH) + ADDRW'(off);
    endfunction

    assign accept   = start && !busy;
    assign busy     = (r_state != kwm_pkg::ST_IDLE);
    assign ld_idx   = IDW'(i_list_id);
    assign ld_id_ok = 32'(i_list_id) < NUM_LISTS;
    assign ld_len   = r_merging ? '0 : r_len[ld_idx];
    assign l_pos    = {r_p, 1'b1};
    assign r_pos    = l_pos + (CNTW+1)'(1);
    assign l_in     = l_pos < {1'b0, r_n};
    assign r_in     = r_pos < {1'b0, r_n};
    assign par_pos  = (r_p - CNTW'(1)) >> 1;
    assign fid_idx  = IDW'(r_fid);
    assign src_idx  = IDW'(r_src);
    assign refill   = r_cur[src_idx] < r_len[src_idx];

    // shared comparator
    kwm_cmp u_cmp (
        .i_x    (r_x.val),
        .i_a    (r_rda.val),
        .i_b    (r_rdb.val),
        .i_b_ok (r_in),
        .o_res  (cmp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kwm_pkg::ST_IDLE: begin
                if (accept && i_kind == kwm_pkg::KIND_POP) begin
                    n_state = r_merging ? kwm_pkg::ST_POP_RD : kwm_pkg::ST_FILL_RD;
                end
            end
            kwm_pkg::ST_FILL_RD: begin
                if (r_fid == CNTW'(NUM_LISTS)) begin
                    n_state = kwm_pkg::ST_HB_NEXT;
                end else if (r_len[fid_idx] != '0) begin
                    n_state = kwm_pkg::ST_FILL_WR;
                end
            end
            kwm_pkg::ST_FILL_WR: n_state = kwm_pkg::ST_FILL_RD;
            kwm_pkg::ST_HB_NEXT: begin
                n_state = (r_i == '0) ? kwm_pkg::ST_POP_RD : kwm_pkg::ST_HB_LD;
            end
            kwm_pkg::ST_HB_LD: n_state = kwm_pkg::ST_SD_RD;
            kwm_pkg::ST_SD_RD: begin
                if (l_in) begin
                    n_state = kwm_pkg::ST_SD_CMP;
                end else if (!r_ctx_pop) begin
                    n_state = kwm_pkg::ST_HB_NEXT;
                end else begin
                    n_state = refill ? kwm_pkg::ST_RF_RD : kwm_pkg::ST_DONE;
                end
            end
            kwm_pkg::ST_SD_CMP: begin
                if (cmp.go_left || cmp.go_right) begin
                    n_state = kwm_pkg::ST_SD_RD;
                end else if (!r_ctx_pop) begin
                    n_state = kwm_pkg::ST_HB_NEXT;
                end else begin
                    n_state = refill ? kwm_pkg::ST_RF_RD : kwm_pkg::ST_DONE;
                end
            end
            kwm_pkg::ST_POP_RD: begin
                n_state = (r_n == '0) ? kwm_pkg::ST_DONE : kwm_pkg::ST_POP_TAKE;
            end
            kwm_pkg::ST_POP_TAKE: n_state = kwm_pkg::ST_SD_RD;
            kwm_pkg::ST_RF_RD:    n_state = kwm_pkg::ST_RF_LD;
            kwm_pkg::ST_RF_LD:    n_state = kwm_pkg::ST_SU_RD;
            kwm_pkg::ST_SU_RD: begin
                n_state = (r_p == '0) ? kwm_pkg::ST_DONE : kwm_pkg::ST_SU_CMP;
            end
            kwm_pkg::ST_SU_CMP: begin
                n_state = cmp.up_swap ? kwm_pkg::ST_SU_RD : kwm_pkg::ST_DONE;
            end
            kwm_pkg::ST_DONE: n_state = kwm_pkg::ST_IDLE;
            default:          n_state = kwm_pkg::ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        st_we    = 1'b0;
        st_waddr = st_addr(ld_idx, OFFW'(ld_len));
        st_raddr = '0;
        hp_we    = 1'b0;
        hp_waddr = IDW'(r_p);
        hp_wdata = r_x;
        hp_ra    = '0;
        hp_rb    = '0;
        case (r_state)
            kwm_pkg::ST_IDLE: begin
                st_we = accept && i_kind == kwm_pkg::KIND_LOAD && ld_id_ok &&
                        (32'(ld_len) < LIST_DEPTH);
            end
            kwm_pkg::ST_FILL_RD: st_raddr = st_addr(fid_idx, '0);
            kwm_pkg::ST_FILL_WR: begin
                hp_we    = 1'b1;
                hp_waddr = IDW'(r_n);
                hp_wdata = '{id: kwm_pkg::t_lid'(r_fid), val: r_st_rd};
            end
            kwm_pkg::ST_HB_NEXT: hp_ra = IDW'(r_i - CNTW'(1));
            kwm_pkg::ST_SD_RD: begin
                hp_ra = IDW'(l_pos);
                hp_rb = r_in ? IDW'(r_pos) : IDW'(l_pos);
                hp_we = !l_in;
            end
            kwm_pkg::ST_SD_CMP: begin
                hp_we = 1'b1;
                if (cmp.go_right) begin
                    hp_wdata = r_rdb;
                end else if (cmp.go_left) begin
                    hp_wdata = r_rda;
                end
            end
            kwm_pkg::ST_POP_RD: begin
                hp_ra = '0;
                hp_rb = IDW'(r_n - CNTW'(1));
            end
            kwm_pkg::ST_RF_RD: st_raddr = st_addr(src_idx, OFFW'(r_cur[src_idx]));
            kwm_pkg::ST_SU_RD: begin
                hp_we = (r_p == '0);
                hp_ra = IDW'(par_pos);
            end
            kwm_pkg::ST_SU_CMP: begin
                hp_we = 1'b1;
                if (cmp.up_swap) begin
                    hp_wdata = r_rda;
                end
            end
            default: begin
                hp_we = 1'b0;
            end
        endcase
    end

    // list store
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= i_value;
        end
        r_st_rd <= r_store[st_raddr];
    end

    // heap ram, two read ports
    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            r_heap[hp_waddr] <= hp_wdata;
        end
        r_rda <= r_heap[hp_ra];
        r_rdb <= r_heap[hp_rb];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LISTS; k++) begin
                r_len[k] <= '0;
                r_cur[k] <= '0;
            end
            r_n       <= '0;
            r_p       <= '0;
            r_i       <= '0;
            r_fid     <= '0;
            r_merging <= 1'b0;
            r_ovf     <= 1'b0;
            r_ctx_pop <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                kwm_pkg::ST_IDLE: begin
                    if (accept && i_kind == kwm_pkg::KIND_LOAD) begin
                        // a load after merging starts a fresh set of lists
                        if (r_merging) begin
                            for (int k = 0; k < NUM_LISTS; k++) begin
                                r_len[k] <= (ld_id_ok && IDW'(k) == ld_idx) ?
                                            LENW'(1) : '0;
                                r_cur[k] <= '0;
                            end
                            r_n       <= '0;
                            r_merging <= 1'b0;
                            r_ovf     <= 1'b0;
                        end else if (ld_id_ok) begin
                            if (32'(ld_len) >= LIST_DEPTH) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_len[ld_idx] <= ld_len + LENW'(1);
                            end
                        end
                    end else if (accept) begin
                        r_ctx_pop <= 1'b0;
                        if (!r_merging) begin
                            r_merging <= 1'b1;
                            r_fid     <= '0;
                            r_n       <= '0;
                        end
                    end
                end
                kwm_pkg::ST_FILL_RD: begin
                    if (r_fid == CNTW'(NUM_LISTS)) begin
                        r_i <= r_n >> 1;
                    end else if (r_len[fid_idx] == '0) begin
                        r_fid <= r_fid + CNTW'(1);
                    end
                end
                kwm_pkg::ST_FILL_WR: begin
                    r_n   <= r_n + CNTW'(1);
                    r_fid <= r_fid + CNTW'(1);
                end
                kwm_pkg::ST_HB_NEXT: begin
                    if (r_i != '0) begin
                        r_p <= r_i - CNTW'(1);
                        r_i <= r_i - CNTW'(1);
                    end
                end
                kwm_pkg::ST_SD_CMP: begin
                    if (cmp.go_right) begin
                        r_p <= CNTW'(r_pos);
                    end else if (cmp.go_left) begin
                        r_p <= CNTW'(l_pos);
                    end
                end
                kwm_pkg::ST_POP_RD: begin
                    r_out_vld <= 1'b0;
                end
                kwm_pkg::ST_POP_TAKE: begin
                    r_out_vld <= 1'b1;
                    r_n       <= r_n - CNTW'(1);
                    r_cur[IDW'(r_rda.id)] <= r_cur[IDW'(r_rda.id)] + LENW'(1);
                    r_src     <= r_rda.id;
                    r_p       <= '0;
                    r_ctx_pop <= 1'b1;
                end
                kwm_pkg::ST_RF_LD: begin
                    r_p <= r_n;
                    r_n <= r_n + CNTW'(1);
                end
                kwm_pkg::ST_SU_CMP: begin
                    if (cmp.up_swap) begin
                        r_p <= par_pos;
                    end
                end
                default: begin
                    r_n <= r_n;
                end
            endcase
        end
    end

    // payload registers: moving element and result fields
    always_ff @(posedge i_clk) begin
        case (r_state)
            kwm_pkg::ST_HB_LD: r_x <= r_rda;
            kwm_pkg::ST_POP_RD: begin
                r_out_val <= '0;
                r_out_src <= '0;
            end
            kwm_pkg::ST_POP_TAKE: begin
                r_x       <= r_rdb;
                r_out_val <= r_rda.val;
                r_out_src <= r_rda.id;
            end
            kwm_pkg::ST_RF_LD: r_x <= '{id: r_src, val: r_st_rd};
            default: r_x <= r_x;
        endcase
    end

    // result ports
    assign o_res_strobe  = (r_state == kwm_pkg::ST_DONE);
    assign o_value_res   = r_out_val;
    assign o_source_list = 3'(r_out_src);
    assign o_valid_res   = r_out_vld;
    assign o_last        = r_out_vld && (r_n == '0);
    assign o_overflow    = r_ovf;

    // checks
    `KWM_ASSERT_ALWAYS(a_heap_bound, 32'(r_n) <= NUM_LISTS, "heap size above list count")
    `KWM_ASSERT_NEXT(a_done_idle, o_res_strobe, !busy, "result not followed by idle")
    `KWM_ASSERT_ALWAYS(a_empty_res, !o_res_strobe || o_valid_res || r_n == '0,
        "empty result with a non-empty heap")
    `KWM_ASSERT_NEXT(a_pop_busy, accept && i_kind == kwm_pkg::KIND_POP, busy,
        "pop request did not start the sequencer")

endmodule

/* test/k_way_merge_min_heap_unit_test.sv */
// testbench of the k-way merge heap unit: random loads and pops checked against a heap model
// depends on kwm_pkg and k_way_merge_min_heap_unit
module k_way_merge_min_heap_unit_test;

    localparam int NL = 8;
    localparam int DEPTH = 64;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic        kind;
        logic [2:0]  lid;
        logic signed [31:0] val;
    } t_req;

    typedef struct packed {
        logic signed [31:0] val;
        logic [2:0]  src;
        logic        valid;
        logic        last;
        logic        ovf;
    } t_pop_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_kind = 1'b0;
    logic [2:0] i_list_id = '0;
    logic signed [31:0] i_value = '0;
    logic o_res_strobe;
    logic signed [31:0] o_value_res;
    logic [2:0] o_source_list;
    logic o_valid_res, o_last, o_overflow;

    k_way_merge_min_heap_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_list_id(i_list_id), .i_value(i_value),
        .o_res_strobe(o_res_strobe), .o_value_res(o_value_res),
        .o_source_list(o_source_list), .o_valid_res(o_valid_res),
        .o_last(o_last), .o_overflow(o_overflow)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // merge model state
    logic signed [31:0] lists [NL][DEPTH];
    int list_len [NL];
    int cursor [NL];
    int heap [NL];
    int heap_n;
    bit merging;
    bit ovf_seen;

    t_req pending_reqs [$];
    t_pop_res expected_pops [$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 0;
    bit quiet_phase = 0;
    logic busy_at_edge;

    function automatic logic signed [31:0] head_of(int slot);
        return lists[heap[slot]][cursor[heap[slot]]];
    endfunction

    function automatic void swap_heap(int a, int b);
        int t;
        t = heap[a];
        heap[a] = heap[b];
        heap[b] = t;
    endfunction

    function automatic void sift_down(int i);
        int l, r, s;
        forever begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            s = i;
            if (l < heap_n && head_of(l) < head_of(i)) s = l;
            if (r < heap_n && head_of(r) < head_of(s)) s = r;
            if (s == i) return;
            swap_heap(i, s);
            i = s;
        end
    endfunction

    function automatic void sift_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (head_of(p) > head_of(i)) begin
                swap_heap(i, p);
                i = p;
            end else begin
                return;
            end
        end
    endfunction

    // apply one accepted request to the model, queue the pop result if any
    function automatic void merge_step(t_req r);
        t_pop_res res;
        int src, k;
        if (r.kind == kwm_pkg::KIND_LOAD) begin
            if (merging) begin
                for (k = 0; k < NL; k++) begin
                    list_len[k] = 0;
                    cursor[k] = 0;
                end
                heap_n = 0;
                merging = 0;
                ovf_seen = 0;
            end
            if (list_len[r.lid] >= DEPTH) begin
                ovf_seen = 1;
            end else begin
                lists[r.lid][list_len[r.lid]] = r.val;
                list_len[r.lid]++;
            end
            return;
        end
        if (!merging) begin
            merging = 1;
            heap_n = 0;
            for (k = 0; k < NL; k++)
                if (list_len[k] > 0) begin
                    heap[heap_n] = k;
                    heap_n++;
                end
            for (k = heap_n / 2; k > 0; k--) sift_down(k - 1);
        end
        res = '0;
        res.ovf = ovf_seen;
        if (heap_n > 0) begin
            src = heap[0];
            res.val = lists[src][cursor[src]];
            cursor[src]++;
            heap_n--;
            heap[0] = heap[heap_n];
            sift_down(0);
            if (cursor[src] < list_len[src]) begin
                heap[heap_n] = src;
                heap_n++;
                sift_up(heap_n - 1);
            end
            res.src = src[2:0];
            res.valid = 1'b1;
            res.last = (heap_n == 0);
        end
        expected_pops.insert(expected_pops.size(), res);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic drive_next();
        t_req r;
        r = pending_reqs.pop_front();
        start <= 1'b1;
        i_kind <= r.kind;
        i_list_id <= r.lid;
        i_value <= r.val;
    endtask

    // request driver with random idle bursts
    int gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy_at_edge) begin
                // previous request taken at the last rising edge
                if (gap == 0 && !quiet_phase && $urandom_range(0, 9) == 0)
                    gap = $urandom_range(1, 19);
                if (gap == 0 && pending_reqs.size() > 0) begin
                    drive_next();
                end else begin
                    start <= 1'b0;
                end
            end else if (!start) begin
                if (gap > 0) gap--;
                else if (pending_reqs.size() > 0) drive_next();
            end
        end
    end

    // acceptance and result monitor
    t_pop_res want;
    always @(posedge i_clk) begin
        busy_at_edge = busy;
        if (i_rst_n) begin
            idle_cycles++;
            if (start && !busy) begin
                merge_step('{kind: i_kind, lid: i_list_id, val: i_value});
                idle_cycles = 0;
            end
            if (o_res_strobe) begin
                idle_cycles = 0;
                if (expected_pops.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_value_res), 64'(0));
                end else begin
                    want = expected_pops.pop_front();
                    if (o_valid_res !== want.valid)
                        report_mismatch("valid_res", 64'(o_valid_res), 64'(want.valid));
                    if (o_value_res !== want.val)
                        report_mismatch("value_res", 64'(o_value_res), 64'(want.val));
                    if (o_source_list !== want.src)
                        report_mismatch("source_list", 64'(o_source_list), 64'(want.src));
                    if (o_last !== want.last)
                        report_mismatch("last", 64'(o_last), 64'(want.last));
                    if (o_overflow !== want.ovf)
                        report_mismatch("overflow", 64'(o_overflow), 64'(want.ovf));
                end
            end
            if (!stim_done && idle_cycles >= WATCH_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 6)) - 3;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic add_req(logic kind, logic [2:0] lid, logic signed [31:0] v);
        t_req r;
        r.kind = kind;
        r.lid = lid;
        r.val = v;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // one load phase followed by pops that drain it, plus a few extra pops
    task automatic add_session(int n_loads, int lists_used, int extra_pops);
        int k;
        int base;
        base = $urandom_range(0, NL - 1);
        for (k = 0; k < n_loads; k++)
            add_req(kwm_pkg::KIND_LOAD,
                    3'((base + $urandom_range(0, lists_used - 1)) % NL), rand_value());
        for (k = 0; k < n_loads + extra_pops; k++)
            add_req(kwm_pkg::KIND_POP, 3'($urandom), $signed($urandom));
    endtask

    int k;
    initial begin
        for (k = 0; k < NL; k++) begin
            list_len[k] = 0;
            cursor[k] = 0;
        end
        heap_n = 0;
        merging = 0;
        ovf_seen = 0;
        busy_at_edge = 0;

        // directed: pop on empty, extremes, equal heads, every list id
        add_req(kwm_pkg::KIND_POP, 3'd0, 32'sd0);
        add_req(kwm_pkg::KIND_LOAD, 3'd0, 32'sh7fffffff);
        add_req(kwm_pkg::KIND_LOAD, 3'd7, 32'sh80000000);
        add_req(kwm_pkg::KIND_LOAD, 3'd3, 32'sd5);
        add_req(kwm_pkg::KIND_LOAD, 3'd4, 32'sd5);
        add_req(kwm_pkg::KIND_LOAD, 3'd3, -32'sd1);
        for (k = 0; k < 7; k++) add_req(kwm_pkg::KIND_POP, 3'd7, 32'shffffffff);
        for (k = 0; k < NL; k++) add_req(kwm_pkg::KIND_LOAD, 3'(k), $signed(32'(k)) - 4);
        for (k = 0; k < 5; k++) add_req(kwm_pkg::KIND_POP, 3'd0, 32'sd0);

        // overflow: one list filled past its depth, then three pops
        for (k = 0; k < DEPTH + 2; k++) add_req(kwm_pkg::KIND_LOAD, 3'd2, $signed(32'(k)));
        add_req(kwm_pkg::KIND_LOAD, 3'd5, 32'sd1);
        for (k = 0; k < 3; k++) add_req(kwm_pkg::KIND_POP, 3'd0, 32'sd0);
        // load after pop clears the overflow flag
        add_req(kwm_pkg::KIND_LOAD, 3'd1, 32'sd9);
        add_req(kwm_pkg::KIND_POP, 3'd0, 32'sd0);
        add_req(kwm_pkg::KIND_POP, 3'd0, 32'sd0);

        // random sessions, mostly small
        while (pending_reqs.size() < 700)
            add_session($urandom_range(1, 24), $urandom_range(1, NL), $urandom_range(0, 2));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_reqs.size() < 40);
        quiet_phase = 1;
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (start || busy || expected_pops.size() > 0) begin
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
            @(posedge i_clk);
        end
        stim_done = 1;
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_pops.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
